// File: hdl/gsp_pkg.sv
// ----------------------------------------------------------------------------
// Glyph run painter package
// Shared field widths, action and register codes, the segment mask table,
// controller state encoding and the command and status bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gsp_pkg;

    // word field widths
    localparam int ACTION_W    = 2;
    localparam int RECORD_W    = 11;
    localparam int READ_ROW_W  = 2;
    localparam int READ_COL_W  = 3;
    localparam int SEG_W       = 8;

    // run record layout
    localparam int REC_STEP_BIT = 10;
    localparam int REC_X0_MSB   = 9;
    localparam int REC_X0_LSB   = 5;
    localparam int REC_X1_MSB   = 4;
    localparam int REC_X1_LSB   = 0;
    localparam int X_W          = 5;

    // pixel to cell geometry
    localparam int SUB_COLS     = 4;
    localparam int SUB_COL_W    = 2;
    localparam int SUB_ROW_W    = 3;
    localparam int CELL_COL_W   = X_W - SUB_COL_W;
    localparam int CELL_ROW_W   = 5;

    // row position and divide by six by reciprocal
    localparam int             ROW_POS_W   = 7;
    localparam logic [6:0]     ROW_POS_MAX = 7'd127;
    localparam int             DIV6_PROD_W = 15;
    localparam logic [14:0]    DIV6_RECIP  = 15'd171;
    localparam int             DIV6_SHIFT  = 10;
    localparam logic [6:0]     SUB_ROWS    = 7'd6;

    // configuration port
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 4;
    localparam int FIRST_COL_W    = 3;
    localparam int NUM_COLS_W     = 4;
    localparam int ROW_COUNT_W    = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_COL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd2;

    localparam logic [FIRST_COL_W-1:0] FIRST_COL_RESET = 3'd0;
    localparam logic [NUM_COLS_W-1:0]  NUM_COLS_RESET  = 4'd8;
    localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RESET = 3'd4;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PAINT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

    // controller states
    typedef enum logic [6:0] {
        ST_SWEEP  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_PREP   = 7'b0000100,
        ST_PAINT  = 7'b0001000,
        ST_DRAIN  = 7'b0010000,
        ST_READ   = 7'b0100000,
        ST_RESULT = 7'b1000000
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_paint;
        logic load_read;
        logic clear_start;
        logic sweep_step;
        logic prep;
        logic paint_step;
        logic read_issue;
        logic result_load;
    } gsp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic window_empty;
        logic paint_empty;
        logic sweep_last;
        logic paint_last;
    } gsp_status_t;

    // segment bit lit by a pixel at (line, column) inside one digit cell
    function automatic logic [SEG_W-1:0] seg_bit(input logic [SUB_ROW_W-1:0] sub_row,
                                                 input logic [SUB_COL_W-1:0] sub_col);
        logic [SEG_W-1:0] bits;
        case ({sub_row, sub_col})
            {3'd0, 2'd1}: bits = 8'h40;
            {3'd1, 2'd0}: bits = 8'h02;
            {3'd1, 2'd2}: bits = 8'h20;
            {3'd2, 2'd1}: bits = 8'h01;
            {3'd3, 2'd0}: bits = 8'h04;
            {3'd3, 2'd2}: bits = 8'h10;
            {3'd4, 2'd1}: bits = 8'h08;
            {3'd4, 2'd3}: bits = 8'h80;
            default:      bits = 8'h00;
        endcase
        return bits;
    endfunction

endpackage

// File: hdl/gsp_if.sv
// ----------------------------------------------------------------------------
// Glyph run painter channels
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gsp_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [gsp_pkg::ACTION_W-1:0]      action;
    logic                              new_glyph;
    logic [gsp_pkg::RECORD_W-1:0]      run_record;
    logic [gsp_pkg::READ_ROW_W-1:0]    read_row;
    logic [gsp_pkg::READ_COL_W-1:0]    read_col;

    modport source (output valid, action, new_glyph, run_record, read_row, read_col,
                    input ready);
    modport sink   (input valid, action, new_glyph, run_record, read_row, read_col,
                    output ready);
endinterface

interface gsp_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [gsp_pkg::SEG_W-1:0]         cell_segments;

    modport source (output valid, cell_segments, input ready);
    modport sink   (input valid, cell_segments, output ready);
endinterface

// File: hdl/glyph_run_to_sevenseg_painter_top.sv
// ----------------------------------------------------------------------------
// Glyph run to seven-segment painter
// Top level: command and result channels, register write port, controller
// and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Paints run records into a DIGIT_ROWS x DIGIT_COLS store of segment bitmaps.
// Words are taken one at a time; ready is high only while the block is idle.
// A paint word spans N digit columns (1 to 8): a setup state, then one column
// read-modify-write per cycle through the store's separate read and write
// ports, then a drain state to retire the last write; an empty run goes back
// to idle at once. A clear word writes one cell of the window per cycle; an
// empty window goes back to idle at once. A read word passes a read state and
// a result state, which waits while an earlier result is still held, and
// returns one result word; the result register lets the next word in while
// the result waits. After reset the whole grid is zeroed by a clearing pass
// during which no word is accepted; register writes are taken at any time.
module glyph_run_to_sevenseg_painter_top #(
    parameter int DIGIT_ROWS = 4,
    parameter int DIGIT_COLS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [gsp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gsp_pkg::CFG_DATA_W-1:0]  cfg_data,
    gsp_cmd_if.sink                         cmd,
    gsp_rsp_if.source                       rsp
);
    import gsp_pkg::*;

    gsp_cmd_t    dp_cmd;
    gsp_status_t dp_status;

    // sequencing
    gsp_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .action    (cmd.action),
        .cmd_ready (cmd.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .status    (dp_status),
        .cmd       (dp_cmd)
    );

    // storage and arithmetic
    gsp_datapath #(
        .DIGIT_ROWS (DIGIT_ROWS),
        .DIGIT_COLS (DIGIT_COLS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .new_glyph     (cmd.new_glyph),
        .run_record    (cmd.run_record),
        .read_row      (cmd.read_row),
        .read_col      (cmd.read_col),
        .cmd           (dp_cmd),
        .status        (dp_status),
        .cell_segments (rsp.cell_segments)
    );

endmodule

// File: hdl/gsp_controller.sv
// ----------------------------------------------------------------------------
// Glyph run painter controller
// Sequences the reset clearing pass, window clears, paint runs and cell reads,
// and owns the result word valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gsp_controller (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    input  logic [gsp_pkg::ACTION_W-1:0]   action,
    output logic                           cmd_ready,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    input  gsp_pkg::gsp_status_t           status,
    output gsp_pkg::gsp_cmd_t              cmd
);
    import gsp_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // next state and datapath commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (action)
                        ACT_CLEAR:
                        begin
                            cmd.clear_start = 1'b1;
                            if (!status.window_empty)
                                state_next = ST_SWEEP;
                        end
                        ACT_PAINT:
                        begin
                            cmd.load_paint = 1'b1;
                            if (!status.paint_empty)
                                state_next = ST_PREP;
                        end
                        ACT_READ:
                        begin
                            cmd.load_read = 1'b1;
                            state_next    = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_PAINT;
            end
            ST_PAINT:
            begin
                cmd.paint_step = 1'b1;
                if (status.paint_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = ST_IDLE;
            end
            ST_READ:
            begin
                cmd.read_issue = 1'b1;
                state_next     = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result word valid flag
    always_comb
    begin
        if (cmd.result_load)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign cmd_ready = (state_reg == ST_IDLE);
    assign rsp_valid = out_valid_reg;

endmodule

// File: hdl/gsp_datapath.sv
// ----------------------------------------------------------------------------
// Glyph run painter datapath
// Window registers, row position, cell store with its sweep and
// read-modify-write paint pipeline, and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gsp_datapath #(
    parameter int DIGIT_ROWS = 4,
    parameter int DIGIT_COLS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [gsp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gsp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              new_glyph,
    input  logic [gsp_pkg::RECORD_W-1:0]      run_record,
    input  logic [gsp_pkg::READ_ROW_W-1:0]    read_row,
    input  logic [gsp_pkg::READ_COL_W-1:0]    read_col,
    input  gsp_pkg::gsp_cmd_t                 cmd,
    output gsp_pkg::gsp_status_t              status,
    output logic [gsp_pkg::SEG_W-1:0]         cell_segments
);
    import gsp_pkg::*;

    localparam int DEPTH = DIGIT_ROWS * DIGIT_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RCW   = $clog2(DIGIT_ROWS + 1);
    localparam int CCW   = $clog2(DIGIT_COLS + 1);

    localparam logic [5:0] COLS_L = 6'(DIGIT_COLS);
    localparam logic [4:0] ROWS_L = 5'(DIGIT_ROWS);

    // configuration registers
    logic [FIRST_COL_W-1:0] first_col_reg;
    logic [NUM_COLS_W-1:0]  num_cols_reg;
    logic [ROW_COUNT_W-1:0] row_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_col_reg <= FIRST_COL_RESET;
            num_cols_reg  <= NUM_COLS_RESET;
            row_count_reg <= ROW_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FIRST_COL: first_col_reg <= cfg_data[FIRST_COL_W-1:0];
                CFG_NUM_COLS:  num_cols_reg  <= cfg_data[NUM_COLS_W-1:0];
                CFG_ROW_COUNT: row_count_reg <= cfg_data[ROW_COUNT_W-1:0];
                default:       first_col_reg <= first_col_reg;
            endcase
        end
    end

    // window limits clipped to the grid
    logic [5:0] col_sum;
    logic [5:0] col_lim_win;
    logic [4:0] row_lim_win;

    assign col_sum     = 6'(first_col_reg) + 6'(num_cols_reg);
    assign col_lim_win = (col_sum > COLS_L) ? COLS_L : col_sum;
    assign row_lim_win = (5'(row_count_reg) > ROWS_L) ? ROWS_L : 5'(row_count_reg);

    assign status.window_empty = (row_lim_win == 5'd0) || (6'(first_col_reg) >= col_lim_win);

    // clear sweep counters, full grid after reset, window on a clear word
    logic           sw_full_reg;
    logic [RCW-1:0] sw_row_reg;
    logic [CCW-1:0] sw_col_reg;
    logic [CCW-1:0] sw_col_first;
    logic [CCW-1:0] sw_col_lim;
    logic [RCW-1:0] sw_row_lim;
    logic           sw_col_wrap;
    logic           sw_row_wrap;
    logic [AW-1:0]  sw_addr;

    assign sw_col_first = sw_full_reg ? '0 : CCW'(first_col_reg);
    assign sw_col_lim   = sw_full_reg ? CCW'(DIGIT_COLS) : CCW'(col_lim_win);
    assign sw_row_lim   = sw_full_reg ? RCW'(DIGIT_ROWS) : RCW'(row_lim_win);
    assign sw_col_wrap  = (sw_col_reg + CCW'(1)) == sw_col_lim;
    assign sw_row_wrap  = (sw_row_reg + RCW'(1)) == sw_row_lim;
    assign sw_addr      = AW'(int'(sw_row_reg) * DIGIT_COLS + int'(sw_col_reg));

    assign status.sweep_last = sw_col_wrap && sw_row_wrap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_full_reg <= 1'b1;
            sw_row_reg  <= '0;
            sw_col_reg  <= '0;
        end
        else if (cmd.clear_start)
        begin
            sw_full_reg <= 1'b0;
            sw_row_reg  <= '0;
            sw_col_reg  <= CCW'(first_col_reg);
        end
        else if (cmd.sweep_step)
        begin
            if (sw_col_wrap)
            begin
                sw_col_reg <= sw_col_first;
                sw_row_reg <= sw_row_reg + RCW'(1);
            end
            else
            begin
                sw_col_reg <= sw_col_reg + CCW'(1);
            end
        end
    end

    // row position, saturating
    logic [ROW_POS_W-1:0] row_pos_reg;
    logic [ROW_POS_W-1:0] row_pos_base;
    logic [ROW_POS_W-1:0] row_pos_next;

    assign row_pos_base = new_glyph ? '0 : row_pos_reg;
    assign row_pos_next = (run_record[REC_STEP_BIT] && (row_pos_base != ROW_POS_MAX)) ?
                          row_pos_base + ROW_POS_W'(1) : row_pos_base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_pos_reg <= '0;
        else if (cmd.load_paint)
            row_pos_reg <= row_pos_next;
    end

    // run span latched on a paint word
    logic [X_W-1:0]        x0_reg;
    logic [X_W-1:0]        x1_reg;
    logic [X_W-1:0]        x1_minus_one;
    logic [CELL_COL_W-1:0] col_cnt_reg;
    logic [CELL_COL_W-1:0] col_last_reg;

    assign x1_minus_one       = run_record[REC_X1_MSB:REC_X1_LSB] - X_W'(1);
    assign status.paint_empty = run_record[REC_X0_MSB:REC_X0_LSB] >=
                                run_record[REC_X1_MSB:REC_X1_LSB];
    assign status.paint_last  = (col_cnt_reg == col_last_reg);

    // digit row and line within it, by multiply with the reciprocal of six
    logic [DIV6_PROD_W-1:0] div_prod;
    logic [CELL_ROW_W-1:0]  cell_row;
    logic [ROW_POS_W-1:0]   sub_row_full;
    logic [CELL_ROW_W-1:0]  cy_reg;
    logic [SUB_ROW_W-1:0]   ym_reg;

    assign div_prod     = DIV6_PROD_W'(row_pos_reg) * DIV6_RECIP;
    assign cell_row     = div_prod[DIV6_SHIFT +: CELL_ROW_W];
    assign sub_row_full = row_pos_reg - ROW_POS_W'(ROW_POS_W'(cell_row) * SUB_ROWS);

    always_ff @(posedge clk)
    begin
        if (cmd.load_paint)
        begin
            x0_reg       <= run_record[REC_X0_MSB:REC_X0_LSB];
            x1_reg       <= run_record[REC_X1_MSB:REC_X1_LSB];
            col_cnt_reg  <= run_record[REC_X0_MSB:REC_X0_LSB + SUB_COL_W];
            col_last_reg <= x1_minus_one[X_W-1:SUB_COL_W];
        end
        else if (cmd.paint_step)
        begin
            col_cnt_reg <= col_cnt_reg + CELL_COL_W'(1);
        end
        if (cmd.prep)
        begin
            cy_reg <= cell_row;
            ym_reg <= sub_row_full[SUB_ROW_W-1:0];
        end
    end

    // segment bits of the run pixels inside the current digit column
    logic [SEG_W-1:0] paint_mask;

    always_comb
    begin
        logic [X_W-1:0] pix_x;
        paint_mask = '0;
        for (int s = 0; s < SUB_COLS; s++)
        begin
            pix_x = {col_cnt_reg, SUB_COL_W'(s)};
            if ((pix_x >= x0_reg) && (pix_x < x1_reg))
                paint_mask = paint_mask | seg_bit(ym_reg, SUB_COL_W'(s));
        end
    end

    // window check and address of the painted cell
    logic          paint_in_window;
    logic [AW-1:0] paint_addr;

    assign paint_in_window = (cy_reg < row_lim_win) &&
                             (col_cnt_reg >= first_col_reg) &&
                             (6'(col_cnt_reg) < col_lim_win);
    assign paint_addr      = AW'(int'(cy_reg) * DIGIT_COLS + int'(col_cnt_reg));

    // write stage of the read-modify-write pipeline
    logic             wr_pend_reg;
    logic [AW-1:0]    wr_addr_reg;
    logic [SEG_W-1:0] wr_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wr_pend_reg <= 1'b0;
        else
            wr_pend_reg <= cmd.paint_step && paint_in_window;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.paint_step)
        begin
            wr_addr_reg <= paint_addr;
            wr_mask_reg <= paint_mask;
        end
    end

    // read word address and off-grid flag
    logic [AW-1:0] rd_addr_reg;
    logic          rd_zero_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_read)
        begin
            rd_addr_reg <= AW'(int'(read_row) * DIGIT_COLS + int'(read_col));
            rd_zero_reg <= (int'(read_row) >= DIGIT_ROWS) || (int'(read_col) >= DIGIT_COLS);
        end
    end

    // cell store, one write and one registered read per cycle
    logic [SEG_W-1:0] cell_mem [DEPTH];
    logic [SEG_W-1:0] rdata_reg;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [SEG_W-1:0] mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;

    assign mem_we    = cmd.sweep_step || wr_pend_reg;
    assign mem_waddr = cmd.sweep_step ? sw_addr : wr_addr_reg;
    assign mem_wdata = cmd.sweep_step ? '0 : (rdata_reg | wr_mask_reg);
    assign mem_re    = cmd.paint_step || cmd.read_issue;
    assign mem_raddr = cmd.read_issue ? rd_addr_reg : paint_addr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            cell_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= cell_mem[mem_raddr];
    end

    // result register
    logic [SEG_W-1:0] cell_seg_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
            cell_seg_reg <= rd_zero_reg ? '0 : rdata_reg;
    end

    assign cell_segments = cell_seg_reg;

endmodule

// File: hdl/gsp_checker.sv
// ----------------------------------------------------------------------------
// Glyph run painter port checker
// Watches the channels of the top level and flags ordering slips.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gsp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cmd_valid,
    input logic                          cmd_ready,
    input logic [gsp_pkg::ACTION_W-1:0]  cmd_action,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [gsp_pkg::SEG_W-1:0]     rsp_cell_segments
);
    import gsp_pkg::*;

    // a waiting result word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_segments))
        else $error("result word changed while stalled");

    // a fresh result follows an accepted read word
    a_rsp_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(cmd_valid && cmd_ready && (cmd_action == ACT_READ), 3))
        else $error("result word without a read word");

    // a read keeps the block busy through its read and result states
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd_action == ACT_READ) |=> !cmd_ready ##1 !cmd_ready)
        else $error("word accepted during a read");

    // clear, paint and unused words give no result
    a_no_rsp_other: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd_action != ACT_READ) |=> !$rose(rsp_valid))
        else $error("result word after a non-read word");

endmodule

bind glyph_run_to_sevenseg_painter_top gsp_checker u_gsp_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (cmd.valid),
    .cmd_ready         (cmd.ready),
    .cmd_action        (cmd.action),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_cell_segments (rsp.cell_segments)
);

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Glyph run painter testbench
// Drives command words into the painter over a valid/ready channel, keeps a
// cycle-free model of the segment store, row position and window registers,
// and checks every returned cell read in order. A short table of directed
// words comes first, then random glyph sequences, read bursts, clears and
// noise under a series of window settings, with bursty sending and a
// stalling receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import gsp_pkg::*;

    localparam int GRID_ROWS    = 4;
    localparam int GRID_COLS    = 8;
    localparam int CLK_HALF     = 10;
    localparam int PHASE_WORDS  = 165;
    localparam int SETTLE_TICKS = 48;
    localparam int QUIET_LIMIT  = 2000;
    localparam int NUM_PHASES   = 10;

    // segment bit per pixel inside a cell, entry (line * 4 + column), entry 0 lowest
    localparam logic [8*24-1:0] SEG_TABLE =
        192'h00000000_80000800_00100004_00000100_00200002_00004000;

    typedef struct packed {
        logic [ACTION_W-1:0]   action;
        logic                  new_glyph;
        logic [RECORD_W-1:0]   run_record;
        logic [READ_ROW_W-1:0] read_row;
        logic [READ_COL_W-1:0] read_col;
    } cmd_word_t;

    typedef struct {
        cmd_word_t      w;
        bit             typed;
        logic [SEG_W-1:0] segs;
    } plan_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    gsp_cmd_if cmd ();
    gsp_rsp_if rsp ();

    glyph_run_to_sevenseg_painter_top #(
        .DIGIT_ROWS(GRID_ROWS),
        .DIGIT_COLS(GRID_COLS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .rsp       (rsp)
    );

    // painter image kept by the testbench
    logic [SEG_W-1:0]       cell_img [GRID_ROWS*GRID_COLS];
    logic [ROW_POS_W-1:0]   glyph_line;
    logic [FIRST_COL_W-1:0] win_first;
    logic [NUM_COLS_W-1:0]  win_cols;
    logic [ROW_COUNT_W-1:0] win_rows;

    logic [SEG_W-1:0] expected_segs [$];
    plan_row_t        plan [$];
    int               fail_count = 0;
    int               burst_left = 0;
    int               quiet_cycles = 0;

    // receiver stall pattern
    int         stall_left = 0;
    int         stall_mode = 0;
    logic [7:0] stall_pat = 8'hff;
    logic [2:0] rcv_tick = '0;

    // window settings per random phase: first column, columns, rows
    int win_first_set [NUM_PHASES] = '{0, 7, 0, 5, 3, 1, 0, 7, 0, 0};
    int win_cols_set  [NUM_PHASES] = '{8, 8, 0, 15, 2, 6, 15, 1, 0, 0};
    int win_rows_set  [NUM_PHASES] = '{4, 4, 0, 7, 2, 3, 1, 4, 0, 0};

    always #(CLK_HALF) clk = ~clk;

    // apply one word to the image, return 1 with the read value when it yields a result
    function automatic bit paint_image(input cmd_word_t w, output logic [SEG_W-1:0] segs);
        int unsigned col_hi;
        int unsigned row_hi;
        int unsigned y;
        int unsigned cy;
        int unsigned cx;
        int unsigned x0;
        int unsigned x1;
        segs   = '0;
        col_hi = int'(win_first) + int'(win_cols);
        if (col_hi > GRID_COLS)
            col_hi = GRID_COLS;
        row_hi = (int'(win_rows) > GRID_ROWS) ? GRID_ROWS : int'(win_rows);
        x0 = w.run_record[REC_X0_MSB:REC_X0_LSB];
        x1 = w.run_record[REC_X1_MSB:REC_X1_LSB];
        case (w.action)
            ACT_CLEAR:
            begin
                for (int unsigned r = 0; r < row_hi; r++)
                    for (int unsigned c = win_first; c < col_hi; c++)
                        cell_img[r*GRID_COLS + c] = '0;
                return 1'b0;
            end
            ACT_PAINT:
            begin
                if (w.new_glyph)
                    glyph_line = '0;
                if (w.run_record[REC_STEP_BIT] && glyph_line != ROW_POS_MAX)
                    glyph_line = glyph_line + 1'b1;
                y  = glyph_line;
                cy = y / 6;
                for (int unsigned x = x0; x < x1; x++)
                begin
                    cx = x / 4;
                    // pixels outside the window are dropped
                    if (cy < row_hi && cx >= win_first && cx < col_hi)
                        cell_img[cy*GRID_COLS + cx] |=
                            SEG_TABLE[((y % 6) * 4 + (x % 4)) * 8 +: 8];
                end
                return 1'b0;
            end
            ACT_READ:
            begin
                if (w.read_row < GRID_ROWS && w.read_col < GRID_COLS)
                    segs = cell_img[w.read_row*GRID_COLS + w.read_col];
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic void plan_word(input logic [ACTION_W-1:0] action,
                                      input logic new_glyph,
                                      input logic [RECORD_W-1:0] rec,
                                      input logic [READ_ROW_W-1:0] rr,
                                      input logic [READ_COL_W-1:0] rc,
                                      input bit typed,
                                      input logic [SEG_W-1:0] segs);
        plan_row_t p;
        p.w     = '{action, new_glyph, rec, rr, rc};
        p.typed = typed;
        p.segs  = segs;
        plan.push_back(p);
    endfunction

    // send one word in bursts with random gaps, predict at acceptance
    task automatic send_word(input cmd_word_t w, input bit typed, input logic [SEG_W-1:0] segs);
        int               gap;
        logic [SEG_W-1:0] predicted;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                cmd.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        cmd.valid      <= 1'b1;
        cmd.action     <= w.action;
        cmd.new_glyph  <= w.new_glyph;
        cmd.run_record <= w.run_record;
        cmd.read_row   <= w.read_row;
        cmd.read_col   <= w.read_col;
        do
            @(posedge clk);
        while (!cmd.ready);
        if (paint_image(w, predicted))
            expected_segs.push_back(typed ? segs : predicted);
    endtask

    // stop sending, wait for every read result and let the block go idle
    task automatic drain_words();
        cmd.valid <= 1'b0;
        while (expected_segs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        case (idx)
            CFG_FIRST_COL: win_first = value[FIRST_COL_W-1:0];
            CFG_NUM_COLS:  win_cols  = value[NUM_COLS_W-1:0];
            CFG_ROW_COUNT: win_rows  = value[ROW_COUNT_W-1:0];
            default: ;
        endcase
    endtask

    // random words: glyph sequences, read bursts, clears and noise
    task automatic run_phase(input int words);
        int        sent;
        int        pick;
        int        span;
        bit        step_on;
        logic [4:0] x0;
        logic [4:0] x1;
        cmd_word_t w;
        sent = 0;
        while (sent < words)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                // a glyph, now and then long enough to pin the row position at its top
                span = ($urandom_range(0, 14) == 0) ? $urandom_range(128, 140)
                                                    : $urandom_range(1, 30);
                for (int i = 0; i < span; i++)
                begin
                    step_on     = (span > 127) || ($urandom_range(0, 9) != 0);
                    w.action    = ACT_PAINT;
                    w.new_glyph = (i == 0);
                    w.read_row  = $urandom_range(0, 3);
                    w.read_col  = $urandom_range(0, 7);
                    if ($urandom_range(0, 4) != 0)
                    begin
                        x0 = $urandom_range(0, 31);
                        x1 = $urandom_range(x0, 31);
                    end
                    else
                    begin
                        x0 = $urandom_range(0, 31);
                        x1 = $urandom_range(0, 31);
                    end
                    w.run_record = {step_on, x0, x1};
                    send_word(w, 1'b0, '0);
                    sent++;
                end
            end
            else if (pick < 80)
            begin
                span = $urandom_range(1, 6);
                for (int i = 0; i < span; i++)
                begin
                    w.action     = ACT_READ;
                    w.new_glyph  = $urandom_range(0, 1);
                    w.run_record = $urandom_range(0, 2047);
                    w.read_row   = $urandom_range(0, 3);
                    w.read_col   = $urandom_range(0, 7);
                    send_word(w, 1'b0, '0);
                    sent++;
                end
            end
            else
            begin
                // clears and noise words of any action
                w.action     = (pick < 85) ? ACT_CLEAR : $urandom_range(0, 3);
                w.new_glyph  = $urandom_range(0, 1);
                w.run_record = $urandom_range(0, 2047);
                w.read_row   = $urandom_range(0, 3);
                w.read_col   = $urandom_range(0, 7);
                send_word(w, 1'b0, '0);
                if (w.action == ACT_CLEAR || w.action == ACT_PAINT || w.action == ACT_READ)
                    sent++;
            end
        end
    endtask

    // receiver: always ready, a repeating pattern, or coin flips
    always @(posedge clk)
    begin
        rcv_tick <= rcv_tick + 1'b1;
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_pat  <= $urandom_range(1, 255);
            stall_left <= $urandom_range(50, 400);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       rsp.ready <= 1'b1;
            1:       rsp.ready <= stall_pat[rcv_tick];
            default: rsp.ready <= $urandom_range(0, 1);
        endcase
    end

    // result check against the oldest expected read
    always @(posedge clk)
    begin : result_check
        logic [SEG_W-1:0] want;
        if (rst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1)
        begin
            if (expected_segs.size() == 0)
            begin
                $error("cell_segments: no read pending, actual %02h", rsp.cell_segments);
                fail_count++;
            end
            else
            begin
                want = expected_segs.pop_front();
                if (rsp.cell_segments !== want)
                begin
                    $error("cell_segments: expected %02h, actual %02h",
                           want, rsp.cell_segments);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        cmd.valid      = 1'b0;
        cmd.action     = '0;
        cmd.new_glyph  = 1'b0;
        cmd.run_record = '0;
        cmd.read_row   = '0;
        cmd.read_col   = '0;
        rsp.ready      = 1'b0;

        foreach (cell_img[i])
            cell_img[i] = '0;
        glyph_line = '0;
        win_first  = FIRST_COL_RESET;
        win_cols   = NUM_COLS_RESET;
        win_rows   = ROW_COUNT_RESET;

        // directed words under the reset window
        plan_word(ACT_READ,  1'b0, 11'h000, 2'd0, 3'd0, 1'b1, 8'h00);
        plan_word(ACT_READ,  1'b0, 11'h000, 2'd3, 3'd7, 1'b1, 8'h00);
        plan_word(ACT_PAINT, 1'b1, {1'b0, 5'd0, 5'd31}, 2'd0, 3'd0, 1'b0, 8'h00);
        plan_word(ACT_READ,  1'b0, 11'h000, 2'd0, 3'd0, 1'b1, 8'h40);
        plan_word(ACT_READ,  1'b0, 11'h000, 2'd0, 3'd7, 1'b1, 8'h40);
        plan_word(ACT_PAINT, 1'b0, {1'b1, 5'd0, 5'd31}, 2'd0, 3'd0, 1'b0, 8'h00);
        plan_word(ACT_READ,  1'b0, 11'h000, 2'd0, 3'd3, 1'b0, 8'h00);
        // empty runs still step the row
        plan_word(ACT_PAINT, 1'b0, {1'b1, 5'd20, 5'd5}, 2'd0, 3'd0, 1'b0, 8'h00);
        plan_word(ACT_PAINT, 1'b0, {1'b1, 5'd7, 5'd7}, 2'd0, 3'd0, 1'b0, 8'h00);
        plan_word(ACT_PAINT, 1'b0, 11'h7ff, 2'd0, 3'd0, 1'b0, 8'h00);
        plan_word(ACT_PAINT, 1'b0, {1'b0, 5'd0, 5'd31}, 2'd0, 3'd0, 1'b0, 8'h00);
        plan_word(ACT_READ,  1'b0, 11'h000, 2'd0, 3'd5, 1'b0, 8'h00);
        // unused action code does nothing
        plan_word(2'd3,      1'b1, 11'h7ff, 2'd3, 3'd7, 1'b0, 8'h00);
        plan_word(ACT_READ,  1'b1, 11'h7ff, 2'd3, 3'd7, 1'b1, 8'h00);
        plan_word(ACT_PAINT, 1'b1, 11'h000, 2'd0, 3'd0, 1'b0, 8'h00);
        plan_word(ACT_PAINT, 1'b1, {1'b1, 5'd12, 5'd16}, 2'd0, 3'd0, 1'b0, 8'h00);
        plan_word(ACT_READ,  1'b0, 11'h000, 2'd1, 3'd0, 1'b1, 8'h00);
        plan_word(ACT_READ,  1'b0, 11'h000, 2'd0, 3'd3, 1'b0, 8'h00);
        plan_word(ACT_CLEAR, 1'b1, 11'h7ff, 2'd3, 3'd7, 1'b0, 8'h00);
        plan_word(ACT_READ,  1'b0, 11'h000, 2'd0, 3'd0, 1'b1, 8'h00);
        plan_word(ACT_READ,  1'b0, 11'h000, 2'd0, 3'd7, 1'b1, 8'h00);
        plan_word(ACT_READ,  1'b0, 11'h000, 2'd2, 3'd4, 1'b1, 8'h00);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
            send_word(plan[i].w, plan[i].typed, plan[i].segs);
        drain_words();

        // random phases, each under its own window
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p >= 8)
            begin
                win_first_set[p] = $urandom_range(0, 7);
                win_cols_set[p]  = $urandom_range(0, 15);
                win_rows_set[p]  = $urandom_range(0, 7);
            end
            write_reg(CFG_FIRST_COL, win_first_set[p]);
            write_reg(CFG_NUM_COLS,  win_cols_set[p]);
            write_reg(CFG_ROW_COUNT, win_rows_set[p]);
            cfg_we <= 1'b0;
            run_phase(PHASE_WORDS);
            drain_words();
        end

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
